// ----- design/eskim_pkg.sv -----
// Shared types and constants for the dijet topology event skim.
package eskim_pkg;

	localparam int unsigned PtW   = 16;
	localparam int unsigned MassW = 16;
	localparam int unsigned EtaW  = 14;
	localparam int unsigned LimW  = 13;
	localparam int unsigned ModeW = 2;
	localparam int unsigned CntW  = 2;
	localparam int unsigned ScoreW = 2;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// item kinds
	localparam logic [ModeW-1:0] MODE_LARGE = 2'd0;
	localparam logic [ModeW-1:0] MODE_SMALL = 2'd1;
	localparam logic [ModeW-1:0] MODE_END   = 2'd2;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_BOOSTED_PT  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ETA_LIMIT   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SOFTDROP    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_REGMASS     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RES_FAT_PT  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_RES_FAT_M   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SMALL_PT    = 3'd6;

	typedef struct packed {
		logic [PtW-1:0]   boosted_pt_min;
		logic [LimW-1:0]  eta_limit;
		logic [MassW-1:0] softdrop_min;
		logic [MassW-1:0] regmass_min;
		logic [PtW-1:0]   resolved_fat_pt_min;
		logic [MassW-1:0] resolved_fat_mass_min;
		logic [PtW-1:0]   small_pt_min;
	} cfg_t;

	typedef struct packed {
		logic is_h;
		logic is_y;
		logic fat_ok;
		logic small_ok;
	} cut_flags_t;

endpackage

// ----- design/eskim_cuts.sv -----
// Per-jet cut evaluation: candidate flags for one registered item.
module eskim_cuts (
	input  eskim_pkg::cfg_t                  cfg,
	input  logic [eskim_pkg::PtW-1:0]        jet_pt,
	input  logic signed [eskim_pkg::EtaW-1:0] jet_eta,
	input  logic [eskim_pkg::MassW-1:0]      softdrop_mass,
	input  logic [eskim_pkg::MassW-1:0]      regressed_mass,
	output eskim_pkg::cut_flags_t            flags
);
	import eskim_pkg::*;

	logic [EtaW-1:0] abs_eta;
	logic            eta_ok;
	logic            base;

	// most negative eta gives 8192, above any 13-bit limit
	assign abs_eta = jet_eta[EtaW-1] ? (~jet_eta + 1'b1) : jet_eta;
	assign eta_ok  = abs_eta < {1'b0, cfg.eta_limit};
	assign base    = (jet_pt > cfg.boosted_pt_min) && eta_ok;

	always_comb begin
		flags.is_h     = base && (regressed_mass > cfg.regmass_min);
		flags.is_y     = base && (softdrop_mass > cfg.softdrop_min);
		flags.fat_ok   = (jet_pt > cfg.resolved_fat_pt_min)
			&& (regressed_mass > cfg.resolved_fat_mass_min) && eta_ok;
		flags.small_ok = (jet_pt > cfg.small_pt_min) && eta_ok;
	end

endmodule

// ----- design/eskim_accum.sv -----
// Per-event counters and the registered score output.
module eskim_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [eskim_pkg::ModeW-1:0]   mode,
	input  eskim_pkg::cut_flags_t         flags,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [eskim_pkg::ScoreW-1:0]  skim_score
);
	import eskim_pkg::*;

	logic [CntW-1:0]   higgs_q, ycand_q, small_q;
	logic              dual_q, fat_q;
	logic              out_valid_q;
	logic [ScoreW-1:0] score_q;
	logic [ScoreW-1:0] score_next;

	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
		return (c < 2'd2) ? c + 1'b1 : 2'd2;
	endfunction

	always_comb begin
		score_next[0] = (higgs_q != '0) && (ycand_q != '0)
			&& !((higgs_q == 2'd1) && (ycand_q == 2'd1) && dual_q);
		score_next[1] = fat_q && (small_q == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			higgs_q     <= '0;
			ycand_q     <= '0;
			small_q     <= '0;
			dual_q      <= 1'b0;
			fat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && (mode == MODE_END))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (fire) begin
				case (mode)
					MODE_LARGE: begin
						if (flags.is_h)
							higgs_q <= sat_inc(higgs_q);
						if (flags.is_y)
							ycand_q <= sat_inc(ycand_q);
						if (flags.is_h && flags.is_y)
							dual_q <= 1'b1;
						if (flags.fat_ok)
							fat_q <= 1'b1;
					end
					MODE_SMALL: begin
						if (flags.small_ok)
							small_q <= sat_inc(small_q);
					end
					MODE_END: begin
						higgs_q     <= '0;
						ycand_q     <= '0;
						small_q     <= '0;
						dual_q      <= 1'b0;
						fat_q       <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (mode == MODE_END))
			score_q <= score_next;
	end

	assign out_valid  = out_valid_q;
	assign skim_score = score_q;

endmodule

// ----- design/dijet_topology_event_skim.sv -----
// Top level of the dijet topology event skim.
// Jets of one event stream in one item per cycle: large jets (mode 0), small jets (mode 1),
// then an end marker (mode 2) that yields one 2-bit score; mode 3 items are dropped. An item
// is registered into s1 and its cuts evaluated there; as it leaves s1 the event counters are
// updated, and an end marker's score is registered for output. Sustained rate is one item per
// cycle; input stalls only when an end marker is held behind a score not yet taken. The user must
// write thresholds through the cfg port only while no event is in flight; the block does not check.
module dijet_topology_event_skim (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [eskim_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [eskim_pkg::CfgDataW-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [eskim_pkg::ModeW-1:0]        mode,
	input  logic [eskim_pkg::PtW-1:0]          jet_pt,
	input  logic signed [eskim_pkg::EtaW-1:0]  jet_eta,
	input  logic [eskim_pkg::MassW-1:0]        softdrop_mass,
	input  logic [eskim_pkg::MassW-1:0]        regressed_mass,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [eskim_pkg::ScoreW-1:0]       skim_score
);
	import eskim_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [ModeW-1:0]  mode_s1;
	logic [PtW-1:0]    pt_s1;
	logic signed [EtaW-1:0] eta_s1;
	logic [MassW-1:0]  msd_s1;
	logic [MassW-1:0]  mreg_s1;
	logic              advance;
	logic              accept;
	cut_flags_t        flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boosted_pt_min        <= 16'd1200;
			cfg_q.eta_limit             <= 13'd2560;
			cfg_q.softdrop_min          <= 16'd120;
			cfg_q.regmass_min           <= 16'd200;
			cfg_q.resolved_fat_pt_min   <= 16'd1000;
			cfg_q.resolved_fat_mass_min <= 16'd200;
			cfg_q.small_pt_min          <= 16'd160;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOOSTED_PT: cfg_q.boosted_pt_min        <= cfg_data;
				REG_ETA_LIMIT:  cfg_q.eta_limit             <= cfg_data[LimW-1:0];
				REG_SOFTDROP:   cfg_q.softdrop_min          <= cfg_data;
				REG_REGMASS:    cfg_q.regmass_min           <= cfg_data;
				REG_RES_FAT_PT: cfg_q.resolved_fat_pt_min   <= cfg_data;
				REG_RES_FAT_M:  cfg_q.resolved_fat_mass_min <= cfg_data;
				REG_SMALL_PT:   cfg_q.small_pt_min          <= cfg_data;
				default: ;
			endcase
		end
	end

	// an end marker waits while the previous score is still held
	assign advance  = valid_s1 && !((mode_s1 == MODE_END) && out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			pt_s1   <= jet_pt;
			eta_s1  <= jet_eta;
			msd_s1  <= softdrop_mass;
			mreg_s1 <= regressed_mass;
		end
	end

	eskim_cuts u_cuts (
		.cfg            (cfg_q),
		.jet_pt         (pt_s1),
		.jet_eta        (eta_s1),
		.softdrop_mass  (msd_s1),
		.regressed_mass (mreg_s1),
		.flags          (flags)
	);

	eskim_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.mode       (mode_s1),
		.flags      (flags),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.skim_score (skim_score)
	);

endmodule
